// ----- hw/rtl/pmpt_pkg.sv -----
// ----------------------------------------------------------------------------
// pmpt_pkg
// Shared types, constants and helper functions for the ps/2 mouse packet
// tracker: field widths, opcodes, register indexes, delta limit and clamp.
// ----------------------------------------------------------------------------
package pmpt_pkg;

	localparam int CoordBits = 12;
	localparam int ClampW = (CoordBits + 2 > 17) ? CoordBits + 2 : 17;

	localparam int CfgAddrW = 3;
	localparam int CfgDataW = CoordBits;

	localparam int InUserW = 2;
	localparam int InTdataW = 48;
	localparam int OutFieldsW = 2 * CoordBits + 26;
	localparam int OutTdataW = ((OutFieldsW + 7) / 8) * 8;

	localparam logic signed [15:0] DeltaHi = 16'sd100;
	localparam logic signed [15:0] DeltaLo = -16'sd100;

	typedef logic [CoordBits-1:0] coord_t;

	localparam coord_t ResetX = coord_t'(320);
	localparam coord_t ResetY = coord_t'(240);
	localparam coord_t ResetMaxX = coord_t'(639);
	localparam coord_t ResetMaxY = coord_t'(479);

	typedef enum logic [1:0] {
		OP_RX_BYTE,
		OP_INJECT,
		OP_SET_POS,
		OP_READ_SCROLL
	} op_t;

	typedef enum logic [CfgAddrW-1:0] {
		REG_ENABLE,
		REG_WHEEL_MODE,
		REG_MIN_X,
		REG_MAX_X,
		REG_MIN_Y,
		REG_MAX_Y
	} reg_idx_t;

	// result word, pos_x in the lowest bits
	typedef struct packed {
		logic updated;
		logic [7:0] scroll_total;
		logic moved;
		logic [7:0] buttons_before;
		logic [7:0] buttons_now;
		coord_t pos_y;
		coord_t pos_x;
	} result_t;

	function automatic logic signed [7:0] limit_delta(input logic signed [15:0] d);
		logic signed [7:0] r;
		if (d > DeltaHi) begin
			r = DeltaHi[7:0];
		end else if (d < DeltaLo) begin
			r = DeltaLo[7:0];
		end else begin
			r = d[7:0];
		end
		return r;
	endfunction

	// raise to lo first, then lower to hi
	function automatic coord_t clamp_to(input logic signed [ClampW-1:0] v,
			input coord_t lo, input coord_t hi);
		logic signed [ClampW-1:0] lo_e;
		logic signed [ClampW-1:0] hi_e;
		logic signed [ClampW-1:0] r;
		lo_e = $signed({{(ClampW-CoordBits){1'b0}}, lo});
		hi_e = $signed({{(ClampW-CoordBits){1'b0}}, hi});
		r = v;
		if (r < lo_e) begin
			r = lo_e;
		end
		if (r > hi_e) begin
			r = hi_e;
		end
		return r[CoordBits-1:0];
	endfunction

endpackage

// ----- hw/rtl/ps2_mouse_packet_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_unit
// Assembles ps/2 mouse packets, tracks a clamped cursor position, buttons and
// a wrapping scroll total; also takes injected deltas, absolute positions and
// scroll read-and-clear requests. One result word per input word.
// ----------------------------------------------------------------------------
// path: an accepted word passes the input register, then
//   one add-and-clamp step into the result register
// throughput: one word per cycle unless the output stalls; position update is
//   one add-limit-clamp path, so back-to-back words each see the previous state
// reset: arst_n clears control and tracking state, not pb_q, at once (position
//   320/240, bounds 0..639 and 0..479, disabled, three-byte packets)
module ps2_mouse_packet_tracker_unit (
	input  logic clk,
	input  logic arst_n,

	input  logic s_tvalid,
	output logic s_tready,
	input  logic [pmpt_pkg::InUserW-1:0] s_tuser,   // opcode
	// rx_byte, arg_x, arg_y, button_bits
	input  logic [pmpt_pkg::InTdataW-1:0] s_tdata,

	output logic m_tvalid,
	input  logic m_tready,
	// pos_x, pos_y, buttons_now, buttons_before, moved, scroll_total, updated
	output logic [pmpt_pkg::OutTdataW-1:0] m_tdata,

	input  logic cfg_we,
	input  logic [pmpt_pkg::CfgAddrW-1:0] cfg_addr,
	input  logic [pmpt_pkg::CfgDataW-1:0] cfg_data
);

	localparam int CW = pmpt_pkg::CoordBits;
	localparam int KW = pmpt_pkg::ClampW;

	// input stage
	logic s1_v_q;
	pmpt_pkg::op_t op_s1;
	logic [7:0] rx_s1;
	logic signed [15:0] arg_x_s1;
	logic signed [15:0] arg_y_s1;
	logic [7:0] btn_s1;

	// configuration
	logic enable_q;
	logic wheel_q;
	pmpt_pkg::coord_t min_x_q, max_x_q, min_y_q, max_y_q;

	// tracking state
	logic [1:0] slot_q;
	logic [7:0] pb_q [3];
	pmpt_pkg::coord_t cur_x_q, cur_y_q, prev_x_q, prev_y_q;
	logic [7:0] btn_now_q, btn_prev_q;
	logic [7:0] scroll_q;

	// result register
	logic m_v_q;
	pmpt_pkg::result_t res_q;

	logic adv;

	// next-state values
	logic [1:0] n_slot;
	pmpt_pkg::coord_t n_cur_x, n_cur_y, n_prev_x, n_prev_y;
	logic [7:0] n_btn_now, n_btn_prev;
	logic [7:0] n_scroll;
	logic [7:0] scroll_out;
	logic upd;
	logic [2:0] pb_we;

	// move path
	logic mv_en;
	logic signed [7:0] mv_dx, mv_dy;
	logic [7:0] mv_btn;
	logic [7:0] b0, b1, b2;
	logic signed [7:0] pk_dx, pk_dy;
	logic signed [KW-1:0] sum_x, sum_y;
	pmpt_pkg::result_t res_d;

	// configuration clamp
	pmpt_pkg::coord_t nb_min_x, nb_max_x, nb_min_y, nb_max_y;
	pmpt_pkg::coord_t cfg_cur_x, cfg_cur_y;

	assign adv = s1_v_q && (!m_v_q || m_tready);
	assign s_tready = !s1_v_q || adv;
	assign m_tvalid = m_v_q;
	assign m_tdata = pmpt_pkg::OutTdataW'(res_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (s_tready) begin
			s1_v_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= pmpt_pkg::op_t'(s_tuser);
			rx_s1 <= s_tdata[7:0];
			arg_x_s1 <= s_tdata[23:8];
			arg_y_s1 <= s_tdata[39:24];
			btn_s1 <= s_tdata[47:40];
		end
	end

	// packet decode
	assign b0 = pb_q[0];
	assign b1 = pb_q[1];
	assign b2 = (slot_q == 2'd2) ? rx_s1 : pb_q[2];
	assign pk_dx = pmpt_pkg::limit_delta({{7{b0[4]}}, b0[4], b1});
	assign pk_dy = pmpt_pkg::limit_delta({{7{b0[5]}}, b0[5], b2});

	always_comb begin
		n_slot = slot_q;
		n_cur_x = cur_x_q;
		n_cur_y = cur_y_q;
		n_prev_x = prev_x_q;
		n_prev_y = prev_y_q;
		n_btn_now = btn_now_q;
		n_btn_prev = btn_prev_q;
		n_scroll = scroll_q;
		upd = 1'b0;
		pb_we = 3'b000;
		mv_en = 1'b0;
		mv_dx = pk_dx;
		mv_dy = -pk_dy;
		mv_btn = {5'b0, b0[2:0]};
		sum_x = '0;
		sum_y = '0;

		case (op_s1)
			pmpt_pkg::OP_RX_BYTE: begin
				if (enable_q) begin
					case (slot_q)
						2'd0: begin
							if (rx_s1[3]) begin
								pb_we[0] = 1'b1;
								n_slot = 2'd1;
							end
						end
						2'd1: begin
							pb_we[1] = 1'b1;
							n_slot = 2'd2;
						end
						2'd2: begin
							pb_we[2] = 1'b1;
							if (wheel_q) begin
								n_slot = 2'd3;
							end else begin
								n_slot = 2'd0;
								mv_en = 1'b1;
							end
						end
						default: begin
							n_slot = 2'd0;
							mv_en = 1'b1;
							if (wheel_q) begin
								n_scroll = scroll_q + {{4{rx_s1[3]}}, rx_s1[3:0]};
							end
						end
					endcase
				end
			end
			pmpt_pkg::OP_INJECT: begin
				if (enable_q) begin
					mv_en = 1'b1;
					mv_dx = pmpt_pkg::limit_delta(arg_x_s1);
					mv_dy = pmpt_pkg::limit_delta(arg_y_s1);
					mv_btn = btn_s1;
				end
			end
			pmpt_pkg::OP_SET_POS: begin
				n_prev_x = cur_x_q;
				n_prev_y = cur_y_q;
				n_cur_x = pmpt_pkg::clamp_to(KW'(arg_x_s1), min_x_q, max_x_q);
				n_cur_y = pmpt_pkg::clamp_to(KW'(arg_y_s1), min_y_q, max_y_q);
				upd = 1'b1;
			end
			default: begin
				n_scroll = 8'd0;
				upd = 1'b1;
			end
		endcase

		if (mv_en) begin
			sum_x = $signed({{(KW-CW){1'b0}}, cur_x_q}) + {{(KW-8){mv_dx[7]}}, mv_dx};
			sum_y = $signed({{(KW-CW){1'b0}}, cur_y_q}) + {{(KW-8){mv_dy[7]}}, mv_dy};
			n_btn_prev = btn_now_q;
			n_btn_now = mv_btn;
			n_prev_x = cur_x_q;
			n_prev_y = cur_y_q;
			n_cur_x = pmpt_pkg::clamp_to(sum_x, min_x_q, max_x_q);
			n_cur_y = pmpt_pkg::clamp_to(sum_y, min_y_q, max_y_q);
			upd = 1'b1;
		end

		scroll_out = (op_s1 == pmpt_pkg::OP_READ_SCROLL) ? scroll_q : n_scroll;

		res_d.pos_x = n_cur_x;
		res_d.pos_y = n_cur_y;
		res_d.buttons_now = n_btn_now;
		res_d.buttons_before = n_btn_prev;
		res_d.moved = (n_cur_x != n_prev_x) || (n_cur_y != n_prev_y);
		res_d.scroll_total = scroll_out;
		res_d.updated = upd;
	end

	// bound writes also pull the position inside the new bounds
	always_comb begin
		nb_min_x = min_x_q;
		nb_max_x = max_x_q;
		nb_min_y = min_y_q;
		nb_max_y = max_y_q;
		case (pmpt_pkg::reg_idx_t'(cfg_addr))
			pmpt_pkg::REG_MIN_X: nb_min_x = cfg_data;
			pmpt_pkg::REG_MAX_X: nb_max_x = cfg_data;
			pmpt_pkg::REG_MIN_Y: nb_min_y = cfg_data;
			pmpt_pkg::REG_MAX_Y: nb_max_y = cfg_data;
			default: ;
		endcase
		cfg_cur_x = pmpt_pkg::clamp_to($signed({{(KW-CW){1'b0}}, cur_x_q}), nb_min_x, nb_max_x);
		cfg_cur_y = pmpt_pkg::clamp_to($signed({{(KW-CW){1'b0}}, cur_y_q}), nb_min_y, nb_max_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			wheel_q <= 1'b0;
			min_x_q <= '0;
			max_x_q <= pmpt_pkg::ResetMaxX;
			min_y_q <= '0;
			max_y_q <= pmpt_pkg::ResetMaxY;
			slot_q <= 2'd0;
			cur_x_q <= pmpt_pkg::ResetX;
			cur_y_q <= pmpt_pkg::ResetY;
			prev_x_q <= '0;
			prev_y_q <= '0;
			btn_now_q <= 8'd0;
			btn_prev_q <= 8'd0;
			scroll_q <= 8'd0;
		end else if (cfg_we) begin
			case (pmpt_pkg::reg_idx_t'(cfg_addr))
				pmpt_pkg::REG_ENABLE: enable_q <= cfg_data[0];
				pmpt_pkg::REG_WHEEL_MODE: wheel_q <= cfg_data[0];
				pmpt_pkg::REG_MIN_X, pmpt_pkg::REG_MAX_X,
				pmpt_pkg::REG_MIN_Y, pmpt_pkg::REG_MAX_Y: begin
					min_x_q <= nb_min_x;
					max_x_q <= nb_max_x;
					min_y_q <= nb_min_y;
					max_y_q <= nb_max_y;
					cur_x_q <= cfg_cur_x;
					cur_y_q <= cfg_cur_y;
				end
				default: ;
			endcase
		end else if (adv) begin
			slot_q <= n_slot;
			cur_x_q <= n_cur_x;
			cur_y_q <= n_cur_y;
			prev_x_q <= n_prev_x;
			prev_y_q <= n_prev_y;
			btn_now_q <= n_btn_now;
			btn_prev_q <= n_btn_prev;
			scroll_q <= n_scroll;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (pb_we[0]) begin
				pb_q[0] <= rx_s1;
			end
			if (pb_we[1]) begin
				pb_q[1] <= rx_s1;
			end
			if (pb_we[2]) begin
				pb_q[2] <= rx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_v_q <= 1'b0;
		end else if (adv) begin
			m_v_q <= 1'b1;
		end else if (m_tready) begin
			m_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

endmodule

// ----- hw/rtl/pmpt_checker.sv -----
// ----------------------------------------------------------------------------
// pmpt_checker
// Port-level checks for the ps/2 mouse packet tracker: result delivery,
// backpressure and stall behavior.
// ----------------------------------------------------------------------------
module pmpt_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [pmpt_pkg::OutTdataW-1:0] m_tdata
);

	// an accepted word that has passed the input and result registers shows up as a result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("accepted word produced no result");

	// input only backs up when a result is waiting and stalled
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result word changed while stalled");

endmodule

bind ps2_mouse_packet_tracker_unit pmpt_checker u_pmpt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
